[hw/rtl/repn_pkg.sv]
// repn_pkg: shared types and constants for the RMS envelope peak normalizer.
// No dependencies.
`default_nettype none
package repn_pkg;
	localparam int MAX_FRAMES_DEF = 4096;
	localparam logic [12:0] HOP_RESET = 13'd735;
	localparam logic [12:0] HOP_MIN = 13'd16;
	localparam logic [12:0] HOP_MAX = 13'd4096;
	localparam logic [41:0] SUM_MAX = {42{1'b1}};

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] sample;
		logic [11:0] frame_index;
	} cmd_t;
endpackage
`default_nettype wire

[hw/rtl/repn_ram.sv]
// repn_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module repn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/repn_queue.sv]
// repn_queue: small FIFO of commands between front and back.
// Depends on repn_pkg.
`default_nettype none
module repn_queue import repn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	input  wire logic pop,
	output cmd_t      pop_data,
	output logic      not_empty,
	output logic      full
);
	cmd_t       entry_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	assign not_empty = cnt_q != 3'd0;
	assign full = cnt_q == 3'd4;
	assign pop_data = entry_q[rd_q];
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule
`default_nettype wire

[hw/rtl/repn_back.sv]
// repn_back: executes commands: square accumulate, hop close with divide and
// integer square root, frame store, normalized read with divide. Depends on repn_pkg, repn_ram.
`default_nettype none
module repn_back import repn_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [12:0] hop_length,
	input  wire logic        cmd_valid,
	input  wire cmd_t        cmd,
	output logic             cmd_pop,
	output logic             idle,
	output logic             done,
	output logic [15:0]      level,
	output logic [12:0]      frame_count,
	output logic             status
);
	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam logic [16:0] MAXF = 17'(MAX_FRAMES);

	typedef enum logic [5:0] {
		ST_RUN  = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_SQRT = 6'b000100,
		ST_RD   = 6'b001000,
		ST_NDIV = 6'b010000,
		ST_OUT  = 6'b100000
	} st_t;

	st_t         st_q;
	logic [41:0] sum_q;
	logic [12:0] pos_q;
	logic [16:0] stored_q;
	logic [15:0] peak_q;
	logic [43:0] rem_q;
	logic [43:0] quo_q;
	logic [12:0] hop_q;
	logic [5:0]  cnt_q;
	logic [15:0] root_q;
	logic [33:0] srem_q;
	logic [31:0] sx_q;
	logic        stat_q;
	logic [15:0] res_q;
	logic        done_q;

	logic [12:0] hop_eff;
	logic [31:0] sq;
	logic [42:0] sum_add;
	logic [41:0] sum_new;
	logic        ram_we;
	logic [15:0] ram_rd;
	logic [AW-1:0] ram_ra;
	logic [44:0] dtrial;
	logic [33:0] strial;
	logic [33:0] srem_sh;
	logic        stored_full;

	assign hop_eff = (hop_length < HOP_MIN) ? HOP_MIN :
		(hop_length > HOP_MAX) ? HOP_MAX : hop_length;
	assign sq = 32'($signed(cmd.sample) * $signed(cmd.sample));
	assign sum_add = {1'b0, sum_q} + {11'b0, sq};
	assign sum_new = sum_add[42] ? SUM_MAX : sum_add[41:0];
	assign stored_full = stored_q >= MAXF;
	assign dtrial = {rem_q, quo_q[43]} - {32'b0, hop_q};
	assign srem_sh = {srem_q[31:0], sx_q[31:30]};
	assign strial = srem_sh - {16'b0, root_q, 2'b01};
	assign ram_we = st_q == ST_SQRT && cnt_q == 6'd0;
	assign ram_ra = AW'(cmd.frame_index);
	assign cmd_pop = cmd_valid && st_q == ST_RUN;
	assign idle = st_q == ST_RUN && !cmd_valid;
	assign done = done_q;
	assign level = res_q;
	assign frame_count = stored_q[12:0];
	assign status = stat_q;

	repn_ram #(.WIDTH(16), .DEPTH(MAX_FRAMES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(stored_q[AW-1:0]), .wdata(root_q),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			sum_q <= '0;
			pos_q <= '0;
			stored_q <= '0;
			peak_q <= 16'd1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_RUN: begin
					if (cmd_valid) begin
						unique case (cmd.func)
							FUNC_PUSH: begin
								if (pos_q + 13'd1 >= hop_eff) begin
									if (stored_full) begin
										sum_q <= '0;
										pos_q <= '0;
										st_q <= ST_OUT;
										cnt_q <= 6'd63;
									end else begin
										quo_q <= {sum_new, 2'b00};
										rem_q <= '0;
										hop_q <= hop_eff;
										cnt_q <= 6'd43;
										st_q <= ST_DIV;
									end
								end else begin
									sum_q <= sum_new;
									pos_q <= pos_q + 13'd1;
								end
							end
							FUNC_CLEAR: begin
								sum_q <= '0;
								pos_q <= '0;
								stored_q <= '0;
								peak_q <= 16'd1;
							end
							FUNC_READ: begin
								stat_q <= !({5'b0, cmd.frame_index} < stored_q &&
									{5'b0, cmd.frame_index} < MAXF);
								st_q <= ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (!dtrial[44]) begin
						rem_q <= dtrial[43:0];
						quo_q <= {quo_q[42:0], 1'b1};
					end else begin
						rem_q <= {rem_q[42:0], quo_q[43]};
						quo_q <= {quo_q[42:0], 1'b0};
					end
					if (cnt_q == 6'd0) begin
						st_q <= ST_SQRT;
						cnt_q <= 6'd22;
						root_q <= '0;
						srem_q <= '0;
					end else cnt_q <= cnt_q - 6'd1;
				end
				ST_SQRT: begin
					if (cnt_q == 6'd22) begin
						sx_q <= (quo_q[43:32] != 12'd0) ? 32'hFFFF_FFFF : quo_q[31:0];
						cnt_q <= 6'd16;
					end else if (cnt_q != 6'd0) begin
						if (!strial[33]) begin
							srem_q <= strial;
							root_q <= {root_q[14:0], 1'b1};
						end else begin
							srem_q <= srem_sh;
							root_q <= {root_q[14:0], 1'b0};
						end
						sx_q <= {sx_q[29:0], 2'b00};
						cnt_q <= cnt_q - 6'd1;
					end else begin
						if (root_q > peak_q) peak_q <= root_q;
						stored_q <= stored_q + 17'd1;
						sum_q <= '0;
						pos_q <= '0;
						st_q <= ST_OUT;
						cnt_q <= 6'd63;
					end
				end
				ST_RD: begin
					quo_q <= {12'b0, ram_rd, 16'b0};
					rem_q <= '0;
					hop_q <= 13'b0;
					cnt_q <= 6'd31;
					st_q <= ST_NDIV;
				end
				ST_NDIV: begin
					if ({rem_q[27:0], quo_q[31]} >= {13'b0, peak_q}) begin
						rem_q <= {15'b0, {rem_q[27:0], quo_q[31]} - {13'b0, peak_q}};
						quo_q <= {quo_q[42:0], 1'b1};
					end else begin
						rem_q <= {15'b0, rem_q[27:0], quo_q[31]};
						quo_q <= {quo_q[42:0], 1'b0};
					end
					if (cnt_q == 6'd0) st_q <= ST_OUT;
					else cnt_q <= cnt_q - 6'd1;
				end
				ST_OUT: begin
					if (cnt_q != 6'd63) done_q <= 1'b1;
					st_q <= ST_RUN;
					cnt_q <= '0;
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_NDIV && cnt_q == 6'd0) begin
			if (stat_q) res_q <= '0;
			else if (quo_q[30:15] != 16'd0) res_q <= 16'hFFFF;
			else res_q <= {quo_q[14:0],
				({rem_q[27:0], quo_q[31]} >= {13'b0, peak_q})};
		end
	end
endmodule
`default_nettype wire

[hw/rtl/repn_front.sv]
// repn_front: command intake and configuration register; queues commands to the back.
// Depends on repn_pkg.
`default_nettype none
module repn_front import repn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] sample,
	input  wire logic [11:0] frame_index,
	input  wire logic        cfg_valid,
	input  wire logic [12:0] cfg_data,
	input  wire logic        q_full,
	output logic             busy,
	output logic             q_push,
	output cmd_t             q_data,
	output logic [12:0]      hop_length
);
	logic [12:0] hop_q;
	assign busy = q_full;
	assign q_push = start && !q_full && func != FUNC_NONE;
	assign q_data = '{func: func_t'(func), sample: sample, frame_index: frame_index};
	assign hop_length = hop_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hop_q <= HOP_RESET;
		else if (cfg_valid) hop_q <= cfg_data;
	end
endmodule
`default_nettype wire

[hw/rtl/rms_envelope_peak_normalizer_core.sv]
// rms_envelope_peak_normalizer_core: top level.
// Depends on repn_pkg, repn_front, repn_queue, repn_back.
// Usage: assert start with func/sample/frame_index; transfer when start && !busy.
// Push samples are handled in the back's run state; the sample closing a hop,
// while the frame store has room, runs a 44-step divide by the hop, a 16-step root
// and the frame store. Reads run a RAM read and a 32-step divide by the peak and
// give one result: done high for one cycle with level, frame_count, status.
// The receiver cannot stall. A four-entry queue between intake and execution
// absorbs bursts; busy rises while it is full.
// Configuration: cfg_valid/cfg_ready transfer hop_length, always ready; write
// only when idle. Reset clears the track, hop_length 735, peak 1. The frame
// store has no clear pass; only written entries give a level.
`default_nettype none
module rms_envelope_peak_normalizer_core import repn_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic signed [15:0] sample,
	input  wire logic [11:0] frame_index,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [12:0] cfg_data,
	output logic             done,
	output logic [15:0]      level,
	output logic [12:0]      frame_count,
	output logic             status
);
	logic        q_full, q_push, q_pop, q_ne, back_idle;
	cmd_t        q_in, q_out;
	logic [12:0] hop_length;

	assign cfg_ready = 1'b1;

	repn_front u_front (
		.clk, .arst_n, .start, .func, .sample, .frame_index, .cfg_valid, .cfg_data,
		.q_full, .busy, .q_push, .q_data(q_in), .hop_length
	);
	repn_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
		.pop_data(q_out), .not_empty(q_ne), .full(q_full)
	);
	repn_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
		.clk, .arst_n, .hop_length, .cmd_valid(q_ne), .cmd(q_out), .cmd_pop(q_pop),
		.idle(back_idle), .done, .level, .frame_count, .status
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push) else $error("push into full queue");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_ne) else $error("pop from empty queue");
	a_status_level: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> level == 16'd0) else $error("level on missing frame");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		back_idle |-> !q_ne) else $error("idle with work queued");
endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking bench for rms_envelope_peak_normalizer_core: drives push/clear/read
// commands with random gaps and checks each read result against a built-in predictor.
// Depends on repn_pkg and the core RTL.
`timescale 1ns / 100ps

typedef struct {
	bit [15:0] lvl;
	bit [12:0] cnt;
	bit        st;
} norm_result_t;

class envelope_board;
	bit [12:0]    hop_reg;
	bit [41:0]    acc;
	int unsigned  pos;
	int unsigned  stored;
	int unsigned  peak;
	bit [15:0]    levels[4096];
	norm_result_t pending[$];
	int           errors;

	function new();
		hop_reg = repn_pkg::HOP_RESET;
		errors = 0;
		clear_track();
	endfunction

	function void clear_track();
		acc = 0;
		pos = 0;
		stored = 0;
		peak = 1;
	endfunction

	function longint unsigned root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function int unsigned hop_eff();
		if (hop_reg < repn_pkg::HOP_MIN)
			return repn_pkg::HOP_MIN;
		if (hop_reg > repn_pkg::HOP_MAX)
			return repn_pkg::HOP_MAX;
		return hop_reg;
	endfunction

	// note one accepted command transfer
	function void note(repn_pkg::func_t f, bit signed [15:0] s, bit [11:0] idx);
		longint signed v;
		longint unsigned t, l;
		int unsigned h;
		norm_result_t r;
		case (f)
			repn_pkg::FUNC_PUSH: begin
				v = s;
				h = hop_eff();
				t = longint'(acc) + v * v;
				acc = (t > repn_pkg::SUM_MAX) ? repn_pkg::SUM_MAX : t[41:0];
				pos++;
				if (pos >= h) begin
					if (stored < 4096) begin
						l = root((longint'(acc) * 4) / h);
						if (l > 65535)
							l = 65535;
						levels[stored] = l[15:0];
						if (l > peak)
							peak = l;
						stored++;
					end
					acc = 0;
					pos = 0;
				end
			end
			repn_pkg::FUNC_CLEAR: begin
				clear_track();
			end
			repn_pkg::FUNC_READ: begin
				r.lvl = 0;
				r.st = 1;
				if (idx < stored) begin
					l = (longint'(levels[idx]) << 16) / peak;
					r.lvl = (l > 65535) ? 16'hFFFF : l[15:0];
					r.st = 0;
				end
				r.cnt = stored[12:0];
				pending.insert(pending.size(), r);
			end
			default: ;
		endcase
	endfunction

	task report(string msg);
		$display("%t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task check(bit [15:0] lvl, bit [12:0] cnt, bit st);
		norm_result_t e;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result level=%0d count=%0d status=%0d", lvl, cnt, st));
		end else begin
			e = pending.pop_front();
			if (lvl != e.lvl)
				report($sformatf("level %0d, expected %0d", lvl, e.lvl));
			if (cnt != e.cnt)
				report($sformatf("frame_count %0d, expected %0d", cnt, e.cnt));
			if (st != e.st)
				report($sformatf("status %0d, expected %0d", st, e.st));
		end
	endtask
endclass

module testbench;
	import repn_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] func = FUNC_NONE;
	logic signed [15:0] sample = 0;
	logic [11:0] frame_index = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [12:0] cfg_data = 0;
	logic done;
	logic [15:0] level;
	logic [12:0] frame_count;
	logic status;

	envelope_board board = new();
	bit quiet;

	rms_envelope_peak_normalizer_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .sample(sample), .frame_index(frame_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .level(level), .frame_count(frame_count), .status(status)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check(level, frame_count, status);
	end

	task send(func_t f, logic [15:0] s, logic [11:0] idx);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		func <= f;
		sample <= s;
		frame_index <= idx;
		do @(posedge clk); while (busy);
		board.note(f, s, idx);
	endtask

	// no result marks the end of a push, so allow the queue to empty at worst case
	task drain();
		start <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task write_hop(logic [12:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.hop_reg = v;
	endtask

	task push_n(int n, logic [15:0] s);
		repeat (n) send(FUNC_PUSH, s, 0);
	endtask

	task random_item();
		int p;
		p = $urandom_range(0, 99);
		if (p < 72)
			send(FUNC_PUSH, (p < 4) ? 16'h8000 : (p < 8) ? 16'h7FFF : 16'($urandom), 0);
		else if (p < 92)
			send(FUNC_READ, 0, (board.stored != 0 && p < 85) ?
				12'($urandom_range(0, board.stored - 1)) : 12'($urandom));
		else if (p < 95)
			send(FUNC_CLEAR, 16'($urandom), 12'($urandom));
		else
			send(FUNC_NONE, 16'($urandom), 12'($urandom));
	endtask

	initial begin
		quiet = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		send(FUNC_READ, 0, 0);
		send(FUNC_NONE, 16'hFFFF, 12'hFFF);
		push_n(3, 16'h7FFF);
		send(FUNC_CLEAR, 0, 0);
		drain();
		write_hop(13'd0);
		push_n(16, 16'h8000);
		send(FUNC_READ, 0, 0);
		push_n(16, 16'h0001);
		send(FUNC_READ, 0, 1);
		send(FUNC_READ, 0, 12'hFFF);
		send(FUNC_CLEAR, 0, 0);
		send(FUNC_READ, 0, 0);
		drain();

		// hop shortened while a hop is open
		write_hop(13'd40);
		push_n(20, 16'h1234);
		drain();
		write_hop(13'd16);
		push_n(1, 16'hC000);
		send(FUNC_READ, 0, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: write_hop(13'd16);
				1: write_hop(13'($urandom_range(17, 40)));
				2: write_hop(13'd4096);
				3: write_hop(13'($urandom_range(0, 15)));
				4: write_hop(13'($urandom_range(4097, 8191)));
				default: write_hop(13'($urandom_range(16, 64)));
			endcase
			send(FUNC_CLEAR, 0, 0);
			for (int i = 0; i < 230; i++) begin
				if (i % 60 == 0)
					quiet = ($urandom_range(0, 2) == 0);
				random_item();
			end
		end
		drain();
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
